FILE: rtl/core/quicksort_engine_top_macros.svh
// Assertion macros for the sort engine; clk and rst_n must be in scope.
`ifndef QUICKSORT_ENGINE_TOP_MACROS_SVH
`define QUICKSORT_ENGINE_TOP_MACROS_SVH
`define QSE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define QSE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/core/qse_pkg.sv
`default_nettype none
package qse_pkg;

    localparam int DEPTH = 1024;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = AW + 1;
    localparam int EW    = 32;
    localparam int SW    = 2 * AW;

    typedef logic signed [EW-1:0] elem_t;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_READ = 1'b1
    } qse_cmd_e;

    typedef struct packed {
        logic                command;
        logic signed [31:0]  value;
        logic [9:0]          index;
        logic                last;
    } qse_req_t;

    typedef struct packed {
        logic signed [31:0]  data_out;
        logic [10:0]         count;
        logic                error;
    } qse_resp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RDWAIT,
        S_INIT,
        S_POP,
        S_POPWAIT,
        S_PIVWAIT,
        S_SCAN,
        S_CMP,
        S_SWWR1,
        S_SWWR2,
        S_FINRD,
        S_FINWR1,
        S_FINWR2,
        S_PUSH1,
        S_PUSH2,
        S_DONE
    } qse_state_t;

endpackage
`default_nettype wire

FILE: rtl/core/qse_ram.sv
`default_nettype none
module qse_ram #(
    parameter int W = 32,
    parameter int D = 1024
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [$clog2(D)-1:0] waddr,
    input  wire logic [W-1:0]         wdata,
    input  wire logic [$clog2(D)-1:0] raddr,
    output logic      [W-1:0]         rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/core/quicksort_engine_top.sv
`default_nettype none
`include "quicksort_engine_top_macros.svh"
// Sort memory for up to 1024 signed 32-bit elements. A transaction is taken
// when start is high and busy is low; results appear for one cycle with done
// high and cannot be stalled, so the receiver must take them when offered.
// A load gives no result unless marked last: then the set is sorted in
// place (Lomuto quicksort, explicit range stack) and one result with the
// count and overflow flag follows. The sort runs on one element RAM with
// one write port and one registered read port, and one compare. A read in
// range waits in S_RDWAIT, with busy high for one cycle, while its data
// passes the RAM read register and the response register; a read out of
// range answers on the next cycle.
module quicksort_engine_top
    import qse_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire qse_req_t  request,
    output logic           done,
    output qse_resp_t      response
);

    qse_state_t     state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           ovf_reg, ovf_next;
    logic           closed_reg, closed_next;
    logic [CW-1:0]  sp_reg, sp_next;
    logic [AW-1:0]  lo_reg, lo_next;
    logic [AW-1:0]  hi_reg, hi_next;
    logic [AW-1:0]  place_reg, place_next;
    logic [AW-1:0]  j_reg, j_next;
    elem_t          pivot_reg, pivot_next;
    elem_t          tmp_reg, tmp_next;
    logic           done_reg, done_next;
    qse_resp_t      resp_reg, resp_next;

    logic           e_we;
    logic [AW-1:0]  e_waddr, e_raddr;
    elem_t          e_wdata, e_rdata;
    logic           s_we;
    logic [AW-1:0]  s_waddr, s_raddr;
    logic [SW-1:0]  s_wdata, s_rdata;

    logic [CW-1:0]  base_count;
    logic           in_range;
    logic           is_less;

    qse_ram #(.W(EW), .D(DEPTH)) u_elem (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    qse_ram #(.W(SW), .D(DEPTH)) u_stack (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign response   = resp_reg;
    assign base_count = closed_reg ? '0 : count_reg;
    assign in_range   = ({1'b0, request.index} < count_reg);
    assign is_less    = (e_rdata < pivot_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (request.command == CMD_LOAD)
                    begin
                        if (request.last)
                        begin
                            state_next = S_INIT;
                        end
                    end
                    else if (in_range)
                    begin
                        state_next = S_RDWAIT;
                    end
                end
            end
            S_RDWAIT:  state_next = S_IDLE;
            S_INIT:    state_next = (count_reg < CW'(2)) ? S_DONE : S_POP;
            S_POP:     state_next = (sp_reg == '0) ? S_DONE : S_POPWAIT;
            S_POPWAIT:
            begin
                if (s_rdata[SW-1:AW] >= s_rdata[AW-1:0])
                begin
                    state_next = S_POP;
                end
                else
                begin
                    state_next = S_PIVWAIT;
                end
            end
            S_PIVWAIT: state_next = S_SCAN;
            S_SCAN:    state_next = (j_reg == hi_reg) ? S_FINRD : S_CMP;
            S_CMP:     state_next = is_less ? S_SWWR1 : S_SCAN;
            S_SWWR1:   state_next = S_SWWR2;
            S_SWWR2:   state_next = S_SCAN;
            S_FINRD:   state_next = S_FINWR1;
            S_FINWR1:  state_next = S_FINWR2;
            S_FINWR2:  state_next = S_PUSH1;
            S_PUSH1:   state_next = S_PUSH2;
            S_PUSH2:   state_next = S_POP;
            S_DONE:    state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        closed_next = closed_reg;
        sp_next     = sp_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        place_next  = place_reg;
        j_next      = j_reg;
        pivot_next  = pivot_reg;
        tmp_next    = tmp_reg;
        done_next   = 1'b0;
        resp_next   = resp_reg;
        e_we        = 1'b0;
        e_waddr     = '0;
        e_wdata     = '0;
        e_raddr     = '0;
        s_we        = 1'b0;
        s_waddr     = '0;
        s_wdata     = '0;
        s_raddr     = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (request.command == CMD_LOAD)
                    begin
                        closed_next = 1'b0;
                        ovf_next    = closed_reg ? 1'b0 : ovf_reg;
                        count_next  = base_count;
                        if (base_count < CW'(DEPTH))
                        begin
                            e_we       = 1'b1;
                            e_waddr    = base_count[AW-1:0];
                            e_wdata    = request.value;
                            count_next = base_count + CW'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else if (in_range)
                    begin
                        e_raddr = request.index;
                    end
                    else
                    begin
                        done_next          = 1'b1;
                        resp_next.data_out = '0;
                        resp_next.count    = count_reg;
                        resp_next.error    = 1'b1;
                    end
                end
            end
            S_RDWAIT:
            begin
                done_next          = 1'b1;
                resp_next.data_out = e_rdata;
                resp_next.count    = count_reg;
                resp_next.error    = 1'b0;
            end
            S_INIT:
            begin
                sp_next = '0;
                if (count_reg >= CW'(2))
                begin
                    s_we    = 1'b1;
                    s_waddr = '0;
                    s_wdata = {AW'(0), AW'(count_reg - CW'(1))};
                    sp_next = CW'(1);
                end
            end
            S_POP:
            begin
                if (sp_reg != '0)
                begin
                    s_raddr = AW'(sp_reg - CW'(1));
                    sp_next = sp_reg - CW'(1);
                end
            end
            S_POPWAIT:
            begin
                lo_next    = s_rdata[SW-1:AW];
                hi_next    = s_rdata[AW-1:0];
                place_next = s_rdata[SW-1:AW];
                j_next     = s_rdata[SW-1:AW];
                e_raddr    = s_rdata[AW-1:0];
            end
            S_PIVWAIT:
            begin
                pivot_next = e_rdata;
            end
            S_SCAN:
            begin
                if (j_reg == hi_reg)
                begin
                    e_raddr = place_reg;
                end
                else
                begin
                    e_raddr = j_reg;
                end
            end
            S_CMP:
            begin
                if (is_less)
                begin
                    tmp_next = e_rdata;
                    e_raddr  = place_reg;
                end
                else
                begin
                    j_next = j_reg + AW'(1);
                end
            end
            S_SWWR1:
            begin
                e_we     = 1'b1;
                e_waddr  = place_reg;
                e_wdata  = tmp_reg;
                tmp_next = e_rdata;
            end
            S_SWWR2:
            begin
                e_we       = 1'b1;
                e_waddr    = j_reg;
                e_wdata    = tmp_reg;
                place_next = place_reg + AW'(1);
                j_next     = j_reg + AW'(1);
            end
            S_FINRD:
            begin
                e_raddr = place_reg;
            end
            S_FINWR1:
            begin
                e_we     = 1'b1;
                e_waddr  = place_reg;
                e_wdata  = pivot_reg;
                tmp_next = e_rdata;
            end
            S_FINWR2:
            begin
                e_we    = 1'b1;
                e_waddr = hi_reg;
                e_wdata = tmp_reg;
            end
            S_PUSH1:
            begin
                if (({1'b0, place_reg} > ({1'b0, lo_reg} + CW'(1))) && (sp_reg < CW'(DEPTH)))
                begin
                    s_we    = 1'b1;
                    s_waddr = sp_reg[AW-1:0];
                    s_wdata = {lo_reg, place_reg - AW'(1)};
                    sp_next = sp_reg + CW'(1);
                end
            end
            S_PUSH2:
            begin
                if ((({1'b0, place_reg} + CW'(1)) < {1'b0, hi_reg}) && (sp_reg < CW'(DEPTH)))
                begin
                    s_we    = 1'b1;
                    s_waddr = sp_reg[AW-1:0];
                    s_wdata = {place_reg + AW'(1), hi_reg};
                    sp_next = sp_reg + CW'(1);
                end
            end
            S_DONE:
            begin
                closed_next        = 1'b1;
                done_next          = 1'b1;
                resp_next.data_out = '0;
                resp_next.count    = count_reg;
                resp_next.error    = ovf_reg;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            closed_reg <= 1'b1;
            sp_reg     <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            closed_reg <= closed_next;
            sp_reg     <= sp_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        place_reg <= place_next;
        j_reg     <= j_next;
        pivot_reg <= pivot_next;
        tmp_reg   <= tmp_next;
        resp_reg  <= resp_next;
    end

    `QSE_ASSERT_IMP(a_done_idle, done, !busy, "result while busy")
    `QSE_ASSERT_IMP(a_sp_bound, 1'b1, sp_reg <= CW'(DEPTH), "range stack overrun")
    `QSE_ASSERT_IMP(a_scan_order, state_reg == S_SCAN,
        (place_reg <= j_reg) && (j_reg <= hi_reg), "scan pointers out of order")
    `QSE_ASSERT_NXT(a_read_answers, start && !busy && request.command == CMD_READ,
        busy || done, "read transaction dropped")

endmodule
`default_nettype wire

FILE: tb/sv/tb_quicksort_engine_top.sv
`default_nettype none
module tb_quicksort_engine_top;
    import qse_pkg::*;

    localparam int WATCHDOG_LIMIT = 10000000;

    class sort_scoreboard;
        logic signed [31:0] store [DEPTH];
        int unsigned        held;
        bit                 overflow;
        bit                 closed;
        qse_resp_t          pending [$];
        int                 mismatches;

        function void clear();
            held = 0;
            overflow = 0;
            closed = 1;
            pending.delete();
            mismatches = 0;
        endfunction

        function void sort_held();
            int lo_q [$];
            int hi_q [$];
            int lo;
            int hi;
            int place;
            logic signed [31:0] pivot;
            logic signed [31:0] t;
            if (held < 2)
                return;
            lo_q.push_back(0);
            hi_q.push_back(held - 1);
            while (lo_q.size() > 0)
            begin
                lo = lo_q.pop_back();
                hi = hi_q.pop_back();
                if (lo >= hi)
                    continue;
                pivot = store[hi];
                place = lo;
                for (int j = lo; j < hi; j++)
                begin
                    if (store[j] < pivot)
                    begin
                        t = store[place];
                        store[place] = store[j];
                        store[j] = t;
                        place++;
                    end
                end
                t = store[place];
                store[place] = store[hi];
                store[hi] = t;
                if (place > lo + 1)
                begin
                    lo_q.push_back(lo);
                    hi_q.push_back(place - 1);
                end
                if (place + 1 < hi)
                begin
                    lo_q.push_back(place + 1);
                    hi_q.push_back(hi);
                end
            end
        endfunction

        function void note_transaction(qse_req_t r);
            qse_resp_t e;
            if (r.command == CMD_LOAD)
            begin
                if (closed)
                begin
                    held = 0;
                    overflow = 0;
                    closed = 0;
                end
                if (held < DEPTH)
                begin
                    store[held] = r.value;
                    held++;
                end
                else
                    overflow = 1;
                if (!r.last)
                    return;
                sort_held();
                closed = 1;
                e.data_out = '0;
                e.count = held[10:0];
                e.error = overflow;
            end
            else
            begin
                e.count = held[10:0];
                if (r.index < held)
                begin
                    e.data_out = store[r.index];
                    e.error = 0;
                end
                else
                begin
                    e.data_out = '0;
                    e.error = 1;
                end
            end
            pending.push_back(e);
        endfunction

        function void check_response(qse_resp_t got);
            qse_resp_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %h", got);
                return;
            end
            e = pending.pop_front();
            if (got.data_out !== e.data_out || got.count !== e.count
                || got.error !== e.error)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp data %0d count %0d err %0d, got %0d %0d %0d",
                             e.data_out, e.count, e.error,
                             got.data_out, got.count, got.error);
            end
        endfunction
    endclass

    logic      clk = 0;
    logic      rst_n = 0;
    logic      start = 0;
    logic      busy;
    qse_req_t  request = '0;
    logic      done;
    qse_resp_t response;

    sort_scoreboard sb;
    int idle_pct;
    int quiet;
    int written;

    quicksort_engine_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .response (response)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_response(response);
        if (rst_n && ((start && !busy) || done))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic issue(qse_cmd_e cmd, logic signed [31:0] v, logic [9:0] idx, logic lst);
        qse_req_t r;
        r.command = cmd;
        r.value = v;
        r.index = idx;
        r.last = lst;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 0;
            @(posedge clk);
        end
        start <= 1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_transaction(r);
    endtask

    task automatic load_set(int n, int mode);
        logic signed [31:0] v;
        for (int i = 0; i < n; i++)
        begin
            case (mode)
                0: v = $urandom;
                1: v = $signed($urandom_range(7)) - 4;
                2: v = i;
                default: v = n - i;
            endcase
            issue(CMD_LOAD, v, 10'($urandom), i == n - 1);
            if ($urandom_range(9) == 0)
                issue(CMD_READ, 0, 10'($urandom_range(n + 2)), 1'($urandom));
        end
    endtask

    task automatic read_back(int n);
        for (int i = 0; i < n; i++)
            issue(CMD_READ, $urandom, 10'($urandom_range(written + 1)), 1'($urandom));
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        written = 0;
        quiet = 0;
        idle_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        issue(CMD_READ, 0, 0, 1);
        issue(CMD_READ, 0, 10'h3ff, 0);
        issue(CMD_LOAD, 32'sh7fffffff, 10'h3ff, 0);
        issue(CMD_LOAD, 32'sh80000000, 0, 0);
        issue(CMD_READ, 0, 0, 0);
        issue(CMD_LOAD, -1, 0, 0);
        issue(CMD_LOAD, 0, 0, 0);
        issue(CMD_LOAD, 5, 0, 0);
        issue(CMD_LOAD, 5, 0, 1);
        written = 6;
        for (int i = 0; i < 7; i++)
            issue(CMD_READ, 0, 10'(i), i[0]);
        issue(CMD_READ, 0, 10'h3ff, 1);
        issue(CMD_LOAD, 42, 0, 1);
        written = 1;
        issue(CMD_READ, 0, 0, 0);
        issue(CMD_READ, 0, 1, 0);

        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 0) ? 10 : (ph == 1) ? 79 : 0;
            for (int s = 0; s < 3; s++)
            begin
                written = $urandom_range(2, 24);
                if ($urandom_range(3) == 0)
                    written = $urandom_range(1, 3);
                load_set(written, $urandom_range(3));
                read_back(written + 4);
            end
        end

        idle_pct = 0;
        for (int i = 0; i < DEPTH + 3; i++)
            issue(CMD_LOAD, $urandom, 10'($urandom), i == DEPTH + 2);
        written = DEPTH;
        issue(CMD_READ, 0, 0, 0);
        issue(CMD_READ, 0, 10'h3ff, 0);
        issue(CMD_READ, 0, 10'h200, 0);
        issue(CMD_LOAD, 7, 0, 1);
        issue(CMD_READ, 0, 10'h3ff, 0);
        start <= 0;

        while (sb.pending.size() > 0 && quiet < WATCHDOG_LIMIT)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
